// ===== rtl/plu_pkg.sv =====
// Shared types, codes and sizing constants for the LL(1) parser unit.
// Depends on nothing; every other RTL file refers to it by scoped names.
package plu_pkg;

   localparam int STACK_DEPTH_DEF      = 256;
   localparam int NUM_PRODUCTIONS_DEF  = 64;
   localparam int MAX_BODY_DEF         = 8;
   localparam int NUM_NONTERMINALS_DEF = 32;
   localparam int NUM_TERMINALS_DEF    = 32;
   localparam int STEP_LIMIT_DEF       = 63;

   // Fixed field widths of the request and response beats and internal registers.
   localparam int OP_W    = 3;
   localparam int IDX5_W  = 5;
   localparam int PROD_W  = 6;
   localparam int POS_W   = 3;
   localparam int SYM_W   = 6;
   localparam int BLEN_W  = 4;
   localparam int EV_W    = 3;
   localparam int ENTRY_W = PROD_W + 1;
   localparam int STEP_W  = 6;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_TABLE_WR = 3'd0,
      OP_SYMBOL_WR = 3'd1,
      OP_LENGTH_WR = 3'd2,
      OP_TOKEN = 3'd3,
      OP_START = 3'd4
   } op_type;

   typedef enum logic [EV_W-1:0] {
      EV_EXPAND = 3'd0,
      EV_MATCH = 3'd1,
      EV_ACCEPT = 3'd2,
      EV_SYNTAX = 3'd3,
      EV_OVERFLOW = 3'd4,
      EV_LIMIT = 3'd5,
      EV_IGNORED = 3'd6
   } event_type;

   localparam logic [CSR_IDX_W-1:0] CSR_START_NT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_T    = 2'd1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_TOKEN, ST_TOP,
      ST_TABLE, ST_LEN, ST_PUSH, ST_EXPAND
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [EV_W-1:0]     ev;
      logic [PROD_W-1:0]   prod;
      logic [SYM_W-1:0]    sym;
      logic [IDX5_W-1:0]   token;
      logic                last;
   } emit_type;

   function automatic int clog2_min1(input int value);
      int r;
      r = $clog2(value);
      return (r < 1) ? 1 : r;
   endfunction

endpackage

// ===== rtl/ll1_table_driven_parser_unit.sv =====
// Top level of the table-driven LL(1) predictive parser.
// Depends on plu_pkg, plu_ram and plu_rsp_reg.
//
//  Channel | Direction | Handshake           | Payload
//  req_    | in        | req_valid/req_stall | operation, table and body fields, token
//  rsp_    | out       | rsp_valid/rsp_stall | event, production, stack symbol, token, last
//  csr_    | in        | csr_we              | csr_index, csr_wdata
//
// Load beats are taken in ST_IDLE, start beats pass ST_START too. A token beat reads
// the stack top in ST_TOKEN and checks it in ST_TOP; each expansion then passes
// ST_TABLE, ST_LEN, ST_PUSH per body symbol and ST_EXPAND, as the sequencer walks
// the table, length and body memories through one read port each and pushes one
// symbol per cycle; a match adds nothing more. After reset the table is cleared one
// entry per cycle, all NUM_NONTERMINALS * NUM_TERMINALS (1024 by default), while
// req_stall stays high. A stalled response holds the sequencer in place; the output
// register lets one result wait while the next is being worked out.
module ll1_table_driven_parser_unit #(
   parameter int STACK_DEPTH      = plu_pkg::STACK_DEPTH_DEF,
   parameter int NUM_PRODUCTIONS  = plu_pkg::NUM_PRODUCTIONS_DEF,
   parameter int MAX_BODY         = plu_pkg::MAX_BODY_DEF,
   parameter int NUM_NONTERMINALS = plu_pkg::NUM_NONTERMINALS_DEF,
   parameter int NUM_TERMINALS    = plu_pkg::NUM_TERMINALS_DEF,
   parameter int STEP_LIMIT       = plu_pkg::STEP_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [plu_pkg::OP_W-1:0]          req_operation,
   input  logic [plu_pkg::IDX5_W-1:0]        req_table_row,
   input  logic [plu_pkg::IDX5_W-1:0]        req_table_column,
   input  logic                              req_entry_valid,
   input  logic [plu_pkg::PROD_W-1:0]        req_production_number,
   input  logic [plu_pkg::POS_W-1:0]         req_symbol_position,
   input  logic [plu_pkg::SYM_W-1:0]         req_symbol_code,
   input  logic [plu_pkg::BLEN_W-1:0]        req_body_length,
   input  logic [plu_pkg::IDX5_W-1:0]        req_token,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [plu_pkg::EV_W-1:0]          rsp_event_res,
   output logic [plu_pkg::PROD_W-1:0]        rsp_production_used,
   output logic [plu_pkg::SYM_W-1:0]         rsp_stack_symbol,
   output logic [plu_pkg::IDX5_W-1:0]        rsp_token_seen,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [plu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plu_pkg::IDX5_W-1:0]        csr_wdata
);
   localparam int TDEPTH = NUM_NONTERMINALS * NUM_TERMINALS;
   localparam int TW     = plu_pkg::clog2_min1(TDEPTH);
   localparam int BDEPTH = NUM_PRODUCTIONS * MAX_BODY;
   localparam int BW     = plu_pkg::clog2_min1(BDEPTH);
   localparam int PW     = plu_pkg::clog2_min1(NUM_PRODUCTIONS);
   localparam int SW     = plu_pkg::clog2_min1(STACK_DEPTH);
   localparam int CW     = $clog2(STACK_DEPTH + 1);
   localparam int LW     = $clog2(MAX_BODY + 1);
   localparam int SYM_W  = plu_pkg::SYM_W;

   plu_pkg::state_type state_ff, state_in;

   logic [plu_pkg::IDX5_W-1:0] start_nt_ff, end_t_ff, token_ff, token_in;
   logic                       active_ff, active_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [plu_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [TW-1:0]              clr_ff, clr_in;
   logic [SYM_W-1:0]           top_ff, top_in;
   logic [plu_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [LW-1:0]              idx_ff, idx_in;

   // Memory ports.
   logic                       stk_we, stk_re;
   logic [SW-1:0]              stk_waddr, stk_raddr;
   logic [SYM_W-1:0]           stk_wdata, stk_rdata;
   logic                       tbl_we, tbl_re;
   logic [TW-1:0]              tbl_waddr, tbl_raddr;
   logic [plu_pkg::ENTRY_W-1:0] tbl_wdata, tbl_rdata;
   logic                       bod_we, bod_re;
   logic [BW-1:0]              bod_waddr, bod_raddr;
   logic [SYM_W-1:0]           bod_rdata;
   logic                       len_we, len_re;
   logic [PW-1:0]              len_waddr, len_raddr;
   logic [LW-1:0]              len_wdata, len_rdata;

   plu_pkg::emit_type          emit;
   logic                       free;

   // Decisions shared by the next-state and datapath blocks.
   logic req_take, limit_hit, stack_empty, top_is_term, top_ends, tab_ok, ovf;
   logic [CW:0] need;

   assign req_stall   = (state_ff != plu_pkg::ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign limit_hit   = (steps_ff >= plu_pkg::STEP_W'(STEP_LIMIT));
   assign stack_empty = (count_ff == '0);
   assign top_is_term = !stk_rdata[SYM_W-1];
   assign top_ends    = limit_hit || stack_empty || top_is_term
                        || (stk_rdata[SYM_W-2:0] >= NUM_NONTERMINALS)
                        || (token_ff >= NUM_TERMINALS);
   assign tab_ok      = tbl_rdata[plu_pkg::ENTRY_W-1]
                        && (tbl_rdata[plu_pkg::PROD_W-1:0] < NUM_PRODUCTIONS);
   assign need        = (CW+1)'(count_ff) - (CW+1)'(1) + (CW+1)'(len_rdata);
   assign ovf         = (need > (CW+1)'(STACK_DEPTH));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_nt_ff <= '0;
         end_t_ff    <= '1;
      end else if (csr_we) begin
         if (csr_index == plu_pkg::CSR_START_NT) begin
            start_nt_ff <= csr_wdata;
         end else if (csr_index == plu_pkg::CSR_END_T) begin
            end_t_ff <= csr_wdata;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plu_pkg::ST_CLEAR: begin
            if (clr_ff == TW'(TDEPTH - 1)) state_in = plu_pkg::ST_IDLE;
         end
         plu_pkg::ST_IDLE: begin
            if (req_take && req_operation == plu_pkg::OP_TOKEN) begin
               state_in = plu_pkg::ST_TOKEN;
            end else if (req_take && req_operation == plu_pkg::OP_START) begin
               state_in = plu_pkg::ST_START;
            end
         end
         plu_pkg::ST_START: state_in = plu_pkg::ST_IDLE;
         plu_pkg::ST_TOKEN: begin
            if (!active_ff) begin
               if (free) state_in = plu_pkg::ST_IDLE;
            end else begin
               state_in = plu_pkg::ST_TOP;
            end
         end
         plu_pkg::ST_TOP: begin
            if (top_ends) begin
               if (free) state_in = plu_pkg::ST_IDLE;
            end else begin
               state_in = plu_pkg::ST_TABLE;
            end
         end
         plu_pkg::ST_TABLE: begin
            if (!tab_ok) begin
               if (free) state_in = plu_pkg::ST_IDLE;
            end else begin
               state_in = plu_pkg::ST_LEN;
            end
         end
         plu_pkg::ST_LEN: begin
            if (ovf) begin
               if (free) state_in = plu_pkg::ST_IDLE;
            end else if (len_rdata == '0) begin
               state_in = plu_pkg::ST_EXPAND;
            end else begin
               state_in = plu_pkg::ST_PUSH;
            end
         end
         plu_pkg::ST_PUSH: begin
            if (idx_ff == '0) state_in = plu_pkg::ST_EXPAND;
         end
         plu_pkg::ST_EXPAND: begin
            if (free) state_in = plu_pkg::ST_TOP;
         end
         default: state_in = plu_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls, memory ports and result beats.
   always_comb begin
      token_in  = token_ff;
      active_in = active_ff;
      count_in  = count_ff;
      steps_in  = steps_ff;
      clr_in    = clr_ff;
      top_in    = top_ff;
      prod_in   = prod_ff;
      idx_in    = idx_ff;
      stk_we    = 1'b0;
      stk_waddr = count_ff[SW-1:0];
      stk_wdata = bod_rdata;
      stk_re    = 1'b0;
      stk_raddr = SW'(count_ff - CW'(1));
      tbl_we    = 1'b0;
      tbl_waddr = clr_ff;
      tbl_wdata = '0;
      tbl_re    = 1'b0;
      tbl_raddr = TW'(int'(stk_rdata[SYM_W-2:0]) * NUM_TERMINALS + int'(token_ff));
      bod_we    = 1'b0;
      bod_waddr = BW'(int'(req_production_number) * MAX_BODY + int'(req_symbol_position));
      bod_re    = 1'b0;
      bod_raddr = BW'(int'(prod_ff) * MAX_BODY + int'(idx_ff) - 1);
      len_we    = 1'b0;
      len_waddr = PW'(req_production_number);
      len_wdata = (req_body_length > MAX_BODY) ? LW'(MAX_BODY) : LW'(req_body_length);
      len_re    = 1'b0;
      len_raddr = PW'(tbl_rdata[plu_pkg::PROD_W-1:0]);
      emit      = '{valid: 1'b0, ev: plu_pkg::EV_IGNORED, prod: '0, sym: '0,
                    token: token_ff, last: 1'b1};
      unique case (state_ff)
         plu_pkg::ST_CLEAR: begin
            tbl_we = 1'b1;
            clr_in = clr_ff + TW'(1);
         end
         plu_pkg::ST_IDLE: begin
            if (req_take) begin
               token_in = req_token;
               unique case (req_operation)
                  plu_pkg::OP_TABLE_WR: begin
                     tbl_waddr = TW'(int'(req_table_row) * NUM_TERMINALS
                                     + int'(req_table_column));
                     tbl_we = (req_table_row < NUM_NONTERMINALS)
                              && (req_table_column < NUM_TERMINALS);
                     if (req_entry_valid && req_production_number < NUM_PRODUCTIONS) begin
                        tbl_wdata = {1'b1, req_production_number};
                     end
                  end
                  plu_pkg::OP_SYMBOL_WR: begin
                     bod_we = (req_production_number < NUM_PRODUCTIONS)
                              && (req_symbol_position < MAX_BODY);
                  end
                  plu_pkg::OP_LENGTH_WR: begin
                     len_we = (req_production_number < NUM_PRODUCTIONS);
                  end
                  plu_pkg::OP_START: begin
                     stk_we    = 1'b1;
                     stk_waddr = '0;
                     stk_wdata = {1'b0, end_t_ff};
                     count_in  = CW'(2);
                     active_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         plu_pkg::ST_START: begin
            stk_we    = 1'b1;
            stk_waddr = SW'(1);
            stk_wdata = {1'b1, start_nt_ff};
         end
         plu_pkg::ST_TOKEN: begin
            steps_in = '0;
            if (!active_ff) begin
               emit.valid = 1'b1;
            end else begin
               stk_re = 1'b1;
            end
         end
         plu_pkg::ST_TOP: begin
            top_in = stk_rdata;
            emit.sym = stack_empty ? '0 : stk_rdata;
            if (top_ends) begin
               emit.valid = 1'b1;
               emit.ev    = plu_pkg::EV_SYNTAX;
               if (limit_hit) begin
                  emit.ev = plu_pkg::EV_LIMIT;
               end else if (!stack_empty && top_is_term
                            && stk_rdata[SYM_W-2:0] == token_ff) begin
                  emit.ev = (token_ff == end_t_ff) ? plu_pkg::EV_ACCEPT : plu_pkg::EV_MATCH;
               end
               if (free) begin
                  if (emit.ev != plu_pkg::EV_MATCH) active_in = 1'b0;
                  if (emit.ev == plu_pkg::EV_MATCH || emit.ev == plu_pkg::EV_ACCEPT) begin
                     count_in = count_ff - CW'(1);
                  end
               end
            end else begin
               tbl_re = 1'b1;
            end
         end
         plu_pkg::ST_TABLE: begin
            prod_in  = tbl_rdata[plu_pkg::PROD_W-1:0];
            emit.sym = top_ff;
            if (!tab_ok) begin
               emit.valid = 1'b1;
               emit.ev    = plu_pkg::EV_SYNTAX;
               if (free) active_in = 1'b0;
            end else begin
               len_re = 1'b1;
            end
         end
         plu_pkg::ST_LEN: begin
            emit.sym = top_ff;
            if (ovf) begin
               emit.valid = 1'b1;
               emit.ev    = plu_pkg::EV_OVERFLOW;
               if (free) active_in = 1'b0;
            end else begin
               // Pop the nonterminal and fetch the last body symbol first.
               count_in  = count_ff - CW'(1);
               idx_in    = len_rdata - LW'(1);
               bod_re    = (len_rdata != '0);
               bod_raddr = BW'(int'(prod_ff) * MAX_BODY + int'(len_rdata) - 1);
            end
         end
         plu_pkg::ST_PUSH: begin
            stk_we   = 1'b1;
            count_in = count_ff + CW'(1);
            if (idx_ff != '0) begin
               bod_re = 1'b1;
               idx_in = idx_ff - LW'(1);
            end
         end
         plu_pkg::ST_EXPAND: begin
            emit.valid = 1'b1;
            emit.ev    = plu_pkg::EV_EXPAND;
            emit.prod  = prod_ff;
            emit.sym   = top_ff;
            emit.last  = 1'b0;
            if (free) begin
               steps_in = steps_ff + plu_pkg::STEP_W'(1);
               stk_re   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= plu_pkg::ST_CLEAR;
         active_ff <= 1'b0;
         count_ff  <= '0;
         clr_ff    <= '0;
         steps_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         count_ff  <= count_in;
         clr_ff    <= clr_in;
         steps_ff  <= steps_in;
      end
      token_ff <= token_in;
      top_ff   <= top_in;
      prod_ff  <= prod_in;
      idx_ff   <= idx_in;
   end

   plu_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata));

   plu_ram #(.WIDTH(plu_pkg::ENTRY_W), .DEPTH(TDEPTH)) u_table (
      .clock(clock), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
      .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata));

   plu_ram #(.WIDTH(SYM_W), .DEPTH(BDEPTH)) u_bodies (
      .clock(clock), .we(bod_we), .waddr(bod_waddr), .wdata(req_symbol_code),
      .re(bod_re), .raddr(bod_raddr), .rdata(bod_rdata));

   plu_ram #(.WIDTH(LW), .DEPTH(NUM_PRODUCTIONS)) u_lengths (
      .clock(clock), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
      .re(len_re), .raddr(len_raddr), .rdata(len_rdata));

   plu_rsp_reg u_rsp (
      .clock(clock), .reset(reset), .emit(emit), .free(free),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res), .rsp_production_used(rsp_production_used),
      .rsp_stack_symbol(rsp_stack_symbol), .rsp_token_seen(rsp_token_seen),
      .rsp_last(rsp_last));
endmodule

// ===== rtl/plu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on plu_pkg for the address width helper.
module plu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [plu_pkg::clog2_min1(DEPTH)-1:0]  waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [plu_pkg::clog2_min1(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/plu_rsp_reg.sv =====
// Response output register: holds one result beat until the consumer takes it.
// Depends on plu_pkg for the emit struct.
module plu_rsp_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  plu_pkg::emit_type             emit,
   output logic                          free,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [plu_pkg::EV_W-1:0]      rsp_event_res,
   output logic [plu_pkg::PROD_W-1:0]    rsp_production_used,
   output logic [plu_pkg::SYM_W-1:0]     rsp_stack_symbol,
   output logic [plu_pkg::IDX5_W-1:0]    rsp_token_seen,
   output logic                          rsp_last
);
   logic              valid_ff, valid_in;
   plu_pkg::emit_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (emit.valid && free) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (emit.valid && free) begin
         data_ff <= emit;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_event_res       = data_ff.ev;
   assign rsp_production_used = data_ff.prod;
   assign rsp_stack_symbol    = data_ff.sym;
   assign rsp_token_seen      = data_ff.token;
   assign rsp_last            = data_ff.last;
endmodule

// ===== rtl/plu_checker.sv =====
// Port-level checks on the parser unit's response beats, bound to the top level.
// Depends on plu_pkg for the event codes.
module plu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [plu_pkg::EV_W-1:0]       rsp_event_res,
   input logic [plu_pkg::PROD_W-1:0]     rsp_production_used,
   input logic                           rsp_last
);
   // A stalled beat stays offered with the same event.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res))
      else $error("response beat dropped or changed under stall");

   // An expansion never ends the handling of a token.
   a_expand_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == plu_pkg::EV_EXPAND |-> !rsp_last)
      else $error("expand beat marked last");

   // Every event other than an expansion or a match is checked to end the token.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != plu_pkg::EV_EXPAND
      && rsp_event_res != plu_pkg::EV_MATCH |-> rsp_last)
      else $error("final event not marked last");

   // Only expansions carry a production number.
   a_prod_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != plu_pkg::EV_EXPAND |-> rsp_production_used == '0)
      else $error("production reported on a non-expand event");
endmodule

bind ll1_table_driven_parser_unit plu_checker u_plu_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_event_res(rsp_event_res), .rsp_production_used(rsp_production_used),
   .rsp_last(rsp_last));
